@@ src/slqs_pkg.sv @@
// Package for the sensor link quality score block: constants, widths, codes,
// item and pipeline stage types. Depends on nothing; every other file imports it.
package slqs_pkg;

  // Fixed scoring constants.
  localparam int unsigned FIELD_COUNT   = 8;
  localparam int unsigned FIELD_PENALTY = 10;
  localparam int unsigned SCORE_MAX     = 100;
  localparam int unsigned VALID_MIN     = 50;
  localparam int unsigned POOR_LIMIT    = 60;
  localparam int unsigned PCT_SCALE     = 100;

  // Field and datapath widths.
  localparam int unsigned TS_W    = 32;
  localparam int unsigned CNT32_W = 32;
  localparam int unsigned SCORE_W = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned TOTAL_W = CNT32_W + 1;
  localparam int unsigned LIM1_W  = LIMIT_W + 1;
  localparam int unsigned PROD_W  = TOTAL_W + LIM1_W;
  localparam int unsigned FCNT_W  = $clog2(FIELD_COUNT + 1);
  localparam int unsigned FPEN_W  = FCNT_W + SCORE_W;
  localparam int unsigned RAW_W   = FPEN_W + 2;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  // Register reset values.
  localparam logic [TS_W-1:0]    TTL_RESET     = 32'd1000;
  localparam logic [SCORE_W-1:0] BASE_RESET    = 8'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 7'd10;
  localparam logic [SCORE_W-1:0] PENALTY_RESET = 8'd20;

  typedef enum logic [CIDX_W-1:0] {
    REG_TTL         = 3'd0,
    REG_BASE        = 3'd1,
    REG_BAD_LIMIT   = 3'd2,
    REG_BAD_PENALTY = 3'd3,
    REG_UART_LIMIT  = 3'd4,
    REG_UART_PENALTY = 3'd5,
    REG_DROP_LIMIT  = 3'd6,
    REG_DROP_COST   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    REASON_NONE   = 2'd0,
    REASON_UNAVAIL = 2'd1,
    REASON_STALE  = 2'd2,
    REASON_POOR   = 2'd3
  } reason_e;

  typedef struct packed {
    logic [TS_W-1:0]    now_ms;
    logic [TS_W-1:0]    latest_frame_ms;
    logic [CNT32_W-1:0] frames_received;
    logic [CNT32_W-1:0] bad_frames;
    logic [CNT32_W-1:0] uart_errors;
    logic [CNT32_W-1:0] frames_dropped;
    logic               bridge_profile;
    logic [MASK_W-1:0]  field_valid_mask;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               score_valid;
    logic               is_stale;
    logic [TS_W-1:0]    frame_age_ms;
    logic [1:0]         reason_code;
  } out_item_t;

  typedef struct packed {
    logic [TS_W-1:0]    ttl_ms;
    logic [SCORE_W-1:0] base_score;
    logic [LIMIT_W-1:0] bad_frame_limit_pct;
    logic [SCORE_W-1:0] bad_frame_penalty;
    logic [LIMIT_W-1:0] uart_error_limit_pct;
    logic [SCORE_W-1:0] uart_error_penalty;
    logic [LIMIT_W-1:0] drop_limit_pct;
    logic [SCORE_W-1:0] drop_cost;
  } cfg_t;

  // After the product stage: both sides of each percentage test.
  typedef struct packed {
    logic              no_frame;
    logic              bridge;
    logic [TS_W-1:0]   age;
    logic [PROD_W-1:0] bad_lhs;
    logic [PROD_W-1:0] bad_rhs;
    logic [PROD_W-1:0] uerr_lhs;
    logic [PROD_W-1:0] uerr_rhs;
    logic [PROD_W-1:0] drop_lhs;
    logic [PROD_W-1:0] drop_rhs;
    logic [FPEN_W-1:0] field_pen;
  } s1_t;

  // After the score stage: unclamped two's complement score.
  typedef struct packed {
    logic             no_frame;
    logic             stale;
    logic [TS_W-1:0]  age;
    logic [RAW_W-1:0] raw;
  } s2_t;

endpackage

@@ src/slqs_ratio_stage.sv @@
// First pipeline stage: frame age and the products behind each percentage test.
// Depends on slqs_pkg.
module slqs_ratio_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  slqs_pkg::in_item_t item_i,
  input  slqs_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  input  logic              ready_i,
  output slqs_pkg::s1_t     data_o
);
  import slqs_pkg::*;

  logic               valid_q;
  s1_t                data_d;
  s1_t                data_q;
  logic [TOTAL_W-1:0] drop_total;
  logic [FCNT_W-1:0]  valid_cnt;
  logic [FCNT_W-1:0]  invalid_cnt;
  logic [LIM1_W-1:0]  bad_lim1;
  logic [LIM1_W-1:0]  uerr_lim1;
  logic [LIM1_W-1:0]  drop_lim1;

  // floor(c * 100 / t) > L is the same as c * 100 >= (L + 1) * t, so no divider.
  always_comb begin
    drop_total = {1'b0, item_i.frames_received} + {1'b0, item_i.frames_dropped};
    bad_lim1   = {1'b0, cfg_i.bad_frame_limit_pct} + LIM1_W'(1);
    uerr_lim1  = {1'b0, cfg_i.uart_error_limit_pct} + LIM1_W'(1);
    drop_lim1  = {1'b0, cfg_i.drop_limit_pct} + LIM1_W'(1);

    valid_cnt = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if ((i < FIELD_COUNT) && item_i.field_valid_mask[i]) begin
        valid_cnt = valid_cnt + FCNT_W'(1);
      end
    end
    invalid_cnt = FCNT_W'(FIELD_COUNT) - valid_cnt;

    data_d.no_frame  = (item_i.frames_received == '0);
    data_d.bridge    = item_i.bridge_profile;
    data_d.age       = item_i.now_ms - item_i.latest_frame_ms;
    data_d.bad_lhs   = PROD_W'(item_i.bad_frames) * PROD_W'(PCT_SCALE);
    data_d.bad_rhs   = PROD_W'(item_i.frames_received) * PROD_W'(bad_lim1);
    data_d.uerr_lhs  = PROD_W'(item_i.uart_errors) * PROD_W'(PCT_SCALE);
    data_d.uerr_rhs  = PROD_W'(item_i.frames_received) * PROD_W'(uerr_lim1);
    data_d.drop_lhs  = PROD_W'(item_i.frames_dropped) * PROD_W'(PCT_SCALE);
    data_d.drop_rhs  = PROD_W'(drop_total) * PROD_W'(drop_lim1);
    data_d.field_pen = FPEN_W'(invalid_cnt) * FPEN_W'(FIELD_PENALTY);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/slqs_score_stage.sv @@
// Second pipeline stage: percentage tests, staleness test and the raw score.
// Depends on slqs_pkg.
module slqs_score_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  slqs_pkg::s1_t  data_i,
  input  slqs_pkg::cfg_t cfg_i,
  output logic           valid_o,
  input  logic           ready_i,
  output slqs_pkg::s2_t  data_o
);
  import slqs_pkg::*;

  logic valid_q;
  s2_t  data_d;
  s2_t  data_q;
  logic bad_over;
  logic uerr_over;
  logic drop_over;

  // The raw score wraps at RAW_W bits but its true range always fits.
  always_comb begin
    bad_over  = (data_i.bad_lhs >= data_i.bad_rhs);
    uerr_over = (data_i.uerr_lhs >= data_i.uerr_rhs);
    drop_over = data_i.bridge && (data_i.drop_lhs >= data_i.drop_rhs);

    data_d.no_frame = data_i.no_frame;
    data_d.stale    = !data_i.no_frame && (data_i.age > cfg_i.ttl_ms);
    data_d.age      = data_i.age;
    data_d.raw      = RAW_W'(cfg_i.base_score)
                    - (bad_over  ? RAW_W'(cfg_i.bad_frame_penalty)  : RAW_W'(0))
                    - (uerr_over ? RAW_W'(cfg_i.uart_error_penalty) : RAW_W'(0))
                    - (drop_over ? RAW_W'(cfg_i.drop_cost)          : RAW_W'(0))
                    - RAW_W'(data_i.field_pen);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/slqs_out_stage.sv @@
// Final pipeline stage and output register: clamping, flags and reason code.
// Depends on slqs_pkg.
module slqs_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  slqs_pkg::s2_t       data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output slqs_pkg::out_item_t item_o
);
  import slqs_pkg::*;

  logic               valid_q;
  out_item_t          item_d;
  out_item_t          item_q;
  logic [SCORE_W-1:0] clamped;

  always_comb begin
    if (data_i.raw[RAW_W-1]) begin
      clamped = '0;
    end else if (data_i.raw[RAW_W-2:0] > (RAW_W-1)'(SCORE_MAX)) begin
      clamped = SCORE_W'(SCORE_MAX);
    end else begin
      clamped = data_i.raw[SCORE_W-1:0];
    end

    if (data_i.no_frame) begin
      item_d.score        = '0;
      item_d.score_valid  = 1'b0;
      item_d.is_stale     = 1'b1;
      item_d.frame_age_ms = '1;
      item_d.reason_code  = REASON_UNAVAIL;
    end else if (data_i.stale) begin
      item_d.score        = '0;
      item_d.score_valid  = 1'b0;
      item_d.is_stale     = 1'b1;
      item_d.frame_age_ms = data_i.age;
      item_d.reason_code  = REASON_STALE;
    end else begin
      item_d.score        = clamped;
      item_d.score_valid  = (clamped >= SCORE_W'(VALID_MIN));
      item_d.is_stale     = 1'b0;
      item_d.frame_age_ms = data_i.age;
      item_d.reason_code  = (clamped < SCORE_W'(POOR_LIMIT)) ? REASON_POOR : REASON_NONE;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/sensor_link_quality_score.sv @@
// Top level of the sensor link quality score block: configuration registers
// and the three-stage pipeline. Depends on slqs_pkg and the slqs_*_stage modules.
//
// Usage
//   Each input item is one snapshot of link counters and timestamps; each one
//   yields exactly one result item, in order. Both channels use valid/ready,
//   and an item moves at a rising edge where valid and ready are both high.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i, with no read-back; they should only be
//   written while no item is in flight.
//   An item passes three register stages in order before its result shows
//   on the output: a product stage (six multipliers of up to 33 by 8 bits
//   that turn each percentage test into a compare), a score stage (the
//   compares and the penalty sum) and an output register (clamping and
//   flags). One item is taken every cycle while the receiver is ready;
//   the throughput is set by those three register stages, each of which
//   refills as soon as the one after it moves on.
//   Reset clears all stage valid bits and loads the registers with their
//   default values. When the receiver stalls, each stage holds its item and
//   the pipeline fills; input ready falls only once all three stages hold an
//   item, so no item is lost or repeated.
module sensor_link_quality_score (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  slqs_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output slqs_pkg::out_item_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [slqs_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [slqs_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import slqs_pkg::*;

  cfg_t cfg_q;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  // Register file: narrower registers keep the low bits of the write data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ttl_ms               <= TTL_RESET;
      cfg_q.base_score           <= BASE_RESET;
      cfg_q.bad_frame_limit_pct  <= LIMIT_RESET;
      cfg_q.bad_frame_penalty    <= PENALTY_RESET;
      cfg_q.uart_error_limit_pct <= LIMIT_RESET;
      cfg_q.uart_error_penalty   <= PENALTY_RESET;
      cfg_q.drop_limit_pct       <= LIMIT_RESET;
      cfg_q.drop_cost            <= PENALTY_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TTL:          cfg_q.ttl_ms               <= cfg_wdata_i[TS_W-1:0];
        REG_BASE:         cfg_q.base_score           <= cfg_wdata_i[SCORE_W-1:0];
        REG_BAD_LIMIT:    cfg_q.bad_frame_limit_pct  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_BAD_PENALTY:  cfg_q.bad_frame_penalty    <= cfg_wdata_i[SCORE_W-1:0];
        REG_UART_LIMIT:   cfg_q.uart_error_limit_pct <= cfg_wdata_i[LIMIT_W-1:0];
        REG_UART_PENALTY: cfg_q.uart_error_penalty   <= cfg_wdata_i[SCORE_W-1:0];
        REG_DROP_LIMIT:   cfg_q.drop_limit_pct       <= cfg_wdata_i[LIMIT_W-1:0];
        REG_DROP_COST:    cfg_q.drop_cost            <= cfg_wdata_i[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  slqs_ratio_stage u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  slqs_score_stage u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .cfg_i   (cfg_q),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  slqs_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

  // Input back-pressure only appears when every stage is occupied and stalled.
  a_full_before_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && s2_valid && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline still had room");

  // A stale or unavailable result never carries a score.
  a_stale_no_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_stale) |->
      (out_item_o.score == '0 && !out_item_o.score_valid &&
       (out_item_o.reason_code == REASON_UNAVAIL ||
        out_item_o.reason_code == REASON_STALE)))
    else $error("stale result with a score or wrong reason");

  // The unavailable case always reports an all-ones age.
  a_unavail_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.reason_code == REASON_UNAVAIL) |->
      (out_item_o.is_stale && out_item_o.frame_age_ms == '1))
    else $error("unavailable result without all-ones age");

  // Fresh results: score within range and flags consistent with it.
  a_fresh_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.is_stale) |->
      (out_item_o.score <= SCORE_W'(SCORE_MAX) &&
       out_item_o.score_valid == (out_item_o.score >= SCORE_W'(VALID_MIN)) &&
       (out_item_o.reason_code == REASON_POOR) ==
         (out_item_o.score < SCORE_W'(POOR_LIMIT))))
    else $error("fresh result flags disagree with its score");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for sensor_link_quality_score: directed snapshots, then random
// snapshots under several register settings, each checked against a typed or predicted result.
// Depends on slqs_pkg and the sensor_link_quality_score RTL only.
`timescale 1ns / 100ps

module tb;
  import slqs_pkg::*;

  localparam int unsigned N_DIRECTED     = 24;
  localparam int unsigned N_PHASES       = 8;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // One row of the directed table. Where typed is set, want holds a result read
  // straight off the specification; otherwise the predictor supplies it.
  typedef struct packed {
    in_item_t  snap;
    logic      typed;
    out_item_t want;
  } probe_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]    cfg_wdata;

  // Register contents as the block should hold them, and the results still owed.
  cfg_t        link_cfg;
  out_item_t   pending_scores[$];
  probe_t      dir_tab [N_DIRECTED];

  bit          calm;
  int unsigned mismatches;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_by_reason [4];
  int unsigned quiet_cycles;

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  sensor_link_quality_score i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact floor percentage; a zero total gives zero.
  function automatic logic [63:0] pct_of(input logic [63:0] count, input logic [63:0] total);
    if (total == 64'd0) begin
      return 64'd0;
    end
    return (count * 64'(PCT_SCALE)) / total;
  endfunction

  // Works out the quality result of one snapshot under the given register settings.
  // Percentages and drop totals are evaluated at 64 bits, so no product or sum can wrap.
  function automatic out_item_t predict_quality(input in_item_t s, input cfg_t c);
    out_item_t   r;
    logic [31:0] age;
    logic [63:0] rx;
    logic [63:0] drop_total;
    int          raw;

    r  = '0;
    rx = {32'd0, s.frames_received};
    if (rx == 64'd0) begin
      r.is_stale     = 1'b1;
      r.frame_age_ms = '1;
      r.reason_code  = REASON_UNAVAIL;
      return r;
    end

    // The subtraction wraps at 32 bits, as the timestamps do.
    age            = s.now_ms - s.latest_frame_ms;
    r.frame_age_ms = age;
    if (age > c.ttl_ms) begin
      r.is_stale    = 1'b1;
      r.reason_code = REASON_STALE;
      return r;
    end

    raw = int'(c.base_score);
    if (pct_of({32'd0, s.bad_frames}, rx) > {57'd0, c.bad_frame_limit_pct}) begin
      raw -= int'(c.bad_frame_penalty);
    end
    if (pct_of({32'd0, s.uart_errors}, rx) > {57'd0, c.uart_error_limit_pct}) begin
      raw -= int'(c.uart_error_penalty);
    end
    drop_total = rx + {32'd0, s.frames_dropped};
    if (s.bridge_profile &&
        pct_of({32'd0, s.frames_dropped}, drop_total) > {57'd0, c.drop_limit_pct}) begin
      raw -= int'(c.drop_cost);
    end
    // Fields beyond the width of the mask always count as invalid.
    for (int i = 0; i < int'(FIELD_COUNT); i++) begin
      if (i >= int'(MASK_W) || !s.field_valid_mask[i]) begin
        raw -= int'(FIELD_PENALTY);
      end
    end

    if (raw > int'(SCORE_MAX)) begin
      raw = int'(SCORE_MAX);
    end
    if (raw < 0) begin
      raw = 0;
    end
    r.score       = raw[SCORE_W-1:0];
    r.score_valid = (raw >= int'(VALID_MIN));
    r.reason_code = (raw < int'(POOR_LIMIT)) ? REASON_POOR : REASON_NONE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t mk(input logic [31:0] now, input logic [31:0] latest,
                                  input logic [31:0] rx, input logic [31:0] bad,
                                  input logic [31:0] uerr, input logic [31:0] drop,
                                  input logic bridge, input logic [7:0] mask);
    in_item_t s;
    s.now_ms           = now;
    s.latest_frame_ms  = latest;
    s.frames_received  = rx;
    s.bad_frames       = bad;
    s.uart_errors      = uerr;
    s.frames_dropped   = drop;
    s.bridge_profile   = bridge;
    s.field_valid_mask = mask;
    return s;
  endfunction

  function automatic out_item_t res(input logic [7:0] sc, input logic v, input logic st,
                                    input logic [31:0] age, input reason_e rc);
    out_item_t r;
    r.score        = sc;
    r.score_valid  = v;
    r.is_stale     = st;
    r.frame_age_ms = age;
    r.reason_code  = rc;
    return r;
  endfunction

  // Mostly short gaps, some medium ones and the odd long one; none while calm.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // A counter placed close to the given percentage of rx, so that the limit
  // compare lands on both sides of its threshold; now and then a wild value.
  function automatic logic [31:0] pick_count(input logic [31:0] rx, input logic [6:0] limit);
    logic [63:0] cnt;
    int          p;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return '1;
      default: begin
        p = int'(limit) + int'($urandom_range(0, 8)) - 4;
        if (p < 0) begin
          p = 0;
        end
        cnt = ({32'd0, rx} * 64'(p)) / 64'd100 + 64'($urandom_range(0, 1));
        return cnt[31:0];
      end
    endcase
  endfunction

  // One random snapshot. Most are fresh, with counters near the limits, so
  // that the penalty logic is reached; the rest are stale, absent or wild.
  function automatic in_item_t gen_snapshot(input cfg_t c);
    in_item_t    s;
    logic [31:0] age;
    logic [31:0] rx;
    case ($urandom_range(0, 9))
      0: age = 32'd0;
      1: age = c.ttl_ms;
      2: age = c.ttl_ms + 32'd1;
      3: age = $urandom;
      default: age = (c.ttl_ms > 32'd20000) ? $urandom_range(0, 20000)
                                            : $urandom_range(0, c.ttl_ms);
    endcase
    case ($urandom_range(0, 9))
      0: rx = 32'd0;
      1: rx = $urandom;
      2: rx = '1;
      default: rx = $urandom_range(1, 2000);
    endcase
    s.now_ms           = $urandom;
    s.latest_frame_ms  = s.now_ms - age;
    s.frames_received  = rx;
    s.bad_frames       = pick_count(rx, c.bad_frame_limit_pct);
    s.uart_errors      = pick_count(rx, c.uart_error_limit_pct);
    s.frames_dropped   = pick_count(rx, c.drop_limit_pct);
    s.bridge_profile   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: s.field_valid_mask = 8'($urandom);
      1: s.field_valid_mask = ~(8'd1 << $urandom_range(0, 7));
      default: s.field_valid_mask = '1;
    endcase
    return s;
  endfunction

  // Register settings for each phase: reset values at both ends, then all
  // ones, all zeros and a few random mixes in between.
  function automatic cfg_t pick_settings(input int unsigned k);
    cfg_t c;
    case (k)
      1: c = '1;
      2: c = '0;
      0, 7: begin
        c.ttl_ms               = TTL_RESET;
        c.base_score           = BASE_RESET;
        c.bad_frame_limit_pct  = LIMIT_RESET;
        c.bad_frame_penalty    = PENALTY_RESET;
        c.uart_error_limit_pct = LIMIT_RESET;
        c.uart_error_penalty   = PENALTY_RESET;
        c.drop_limit_pct       = LIMIT_RESET;
        c.drop_cost            = PENALTY_RESET;
      end
      default: begin
        c.ttl_ms               = ($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 5000);
        c.base_score           = 8'($urandom_range(40, 255));
        c.bad_frame_limit_pct  = 7'($urandom_range(0, 127));
        c.bad_frame_penalty    = 8'($urandom_range(0, 60));
        c.uart_error_limit_pct = 7'($urandom_range(0, 100));
        c.uart_error_penalty   = 8'($urandom_range(0, 255));
        c.drop_limit_pct       = 7'($urandom_range(0, 127));
        c.drop_cost            = 8'($urandom_range(0, 60));
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks; each is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one item, holds it until accepted, records its expected result and
  // then leaves the channel idle for the requested gap.
  task automatic send_snapshot(input in_item_t snap, input out_item_t want,
                               input int unsigned gap);
    in_item  <= snap;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_scores.push_back(want);
    n_sent++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every result owed has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Writes every register. The unused upper bits of the narrow registers carry
  // random junk, which the block must drop.
  task automatic program_settings(input cfg_t c);
    logic [CFG_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_TTL, c.ttl_ms);
    write_reg(REG_BASE, {junk[31:8], c.base_score});
    write_reg(REG_BAD_LIMIT, {junk[31:7], c.bad_frame_limit_pct});
    write_reg(REG_BAD_PENALTY, {junk[31:8], c.bad_frame_penalty});
    write_reg(REG_UART_LIMIT, {junk[31:7], c.uart_error_limit_pct});
    write_reg(REG_UART_PENALTY, {junk[31:8], c.uart_error_penalty});
    write_reg(REG_DROP_LIMIT, {junk[31:7], c.drop_limit_pct});
    write_reg(REG_DROP_COST, {junk[31:8], c.drop_cost});
    cfg_we   <= 1'b0;
    link_cfg  = c;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch on result %0d: %s", $time, n_checked, msg);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.score !== want.score) begin
      report_mismatch($sformatf("score %0d, expected %0d", got.score, want.score));
    end
    if (got.score_valid !== want.score_valid) begin
      report_mismatch($sformatf("score_valid %b, expected %b",
                                got.score_valid, want.score_valid));
    end
    if (got.is_stale !== want.is_stale) begin
      report_mismatch($sformatf("is_stale %b, expected %b", got.is_stale, want.is_stale));
    end
    if (got.frame_age_ms !== want.frame_age_ms) begin
      report_mismatch($sformatf("frame_age_ms %h, expected %h",
                                got.frame_age_ms, want.frame_age_ms));
    end
    if (got.reason_code !== want.reason_code) begin
      report_mismatch($sformatf("reason_code %0d, expected %0d",
                                got.reason_code, want.reason_code));
    end
  endtask

  // Output values are read at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("result item with none expected");
      end else begin
        check_result(out_item, pending_scores[0]);
        n_by_reason[pending_scores[0].reason_code]++;
        void'(pending_scores.pop_front());
      end
      n_checked++;
    end
  end

  // Ends the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles, %0d results still owed",
                 quiet_cycles, pending_scores.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: runs of ready, mostly short with the odd long stretch, broken by
  // stalls from the same distribution as the sender's gaps.
  initial begin
    int unsigned run;
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    out_item_t want;
    in_item_t  snap;

    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_TTL;
    cfg_wdata = '0;
    calm      = 1'b0;
    rst_n     = 1'b0;
    link_cfg  = pick_settings(0);

    // Directed table, run under the reset values of the registers. The first
    // rows cover no frame at all, the TTL boundary, timestamp wrap-around and
    // all fields invalid; the rest sit on each percentage threshold, on the
    // bridge-only drop penalty, on full-scale counters, on clamping to zero
    // and on the valid and poor score boundaries.
    dir_tab = '{
      '{mk('1, 32'd0, 32'd0, '1, '1, '1, 1'b1, 8'hFF), 1'b1,
        res(8'd0, 1'b0, 1'b1, '1, REASON_UNAVAIL)},
      '{mk(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 8'h00), 1'b1,
        res(8'd0, 1'b0, 1'b1, '1, REASON_UNAVAIL)},
      '{mk(32'd1000, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 8'hFF), 1'b1,
        res(8'd100, 1'b1, 1'b0, 32'd1000, REASON_NONE)},
      '{mk(32'd1001, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 8'hFF), 1'b1,
        res(8'd0, 1'b0, 1'b1, 32'd1001, REASON_STALE)},
      '{mk(32'd5, '1, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 8'hFF), 1'b1,
        res(8'd100, 1'b1, 1'b0, 32'd6, REASON_NONE)},
      '{mk(32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 8'hFF), 1'b1,
        res(8'd0, 1'b0, 1'b1, '1, REASON_STALE)},
      '{mk('1, '1, '1, 32'd0, 32'd0, 32'd0, 1'b1, 8'h00), 1'b1,
        res(8'd20, 1'b0, 1'b0, 32'd0, REASON_POOR)},
      '{mk(32'd500, 32'd400, 32'd100, 32'd10, 32'd0, 32'd0, 1'b0, 8'hFF), 1'b0, '0},
      '{mk(32'd500, 32'd400, 32'd100, 32'd11, 32'd0, 32'd0, 1'b0, 8'hFF), 1'b0, '0},
      '{mk(32'd500, 32'd400, 32'd100, 32'd0, 32'd10, 32'd0, 1'b0, 8'hFF), 1'b0, '0},
      '{mk(32'd500, 32'd400, 32'd100, 32'd0, 32'd11, 32'd0, 1'b0, 8'hFF), 1'b0, '0},
      '{mk(32'd20, 32'd10, 32'd90, 32'd0, 32'd0, 32'd10, 1'b1, 8'hFF), 1'b0, '0},
      '{mk(32'd20, 32'd10, 32'd89, 32'd0, 32'd0, 32'd11, 1'b1, 8'hFF), 1'b0, '0},
      '{mk(32'd20, 32'd10, 32'd89, 32'd0, 32'd0, 32'd11, 1'b0, 8'hFF), 1'b0, '0},
      '{mk(32'd7, 32'd7, '1, '1, '1, '1, 1'b1, 8'hFF), 1'b0, '0},
      '{mk(32'd7, 32'd7, 32'd1, '1, '1, '1, 1'b1, 8'h00), 1'b0, '0},
      '{mk(32'd9, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0, 1'b0, 8'h01), 1'b0, '0},
      '{mk(32'd9, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0, 1'b1, 8'h80), 1'b0, '0},
      '{mk(32'd9, 32'd0, 32'd3, 32'd1, 32'd0, 32'd0, 1'b0, 8'h55), 1'b0, '0},
      '{mk(32'd9, 32'd0, 32'd3, 32'd0, 32'd1, 32'd0, 1'b1, 8'hAA), 1'b0, '0},
      '{mk(32'd60, 32'd0, 32'd100, 32'd11, 32'd0, 32'd0, 1'b0, 8'h3F), 1'b0, '0},
      '{mk(32'd60, 32'd0, 32'd100, 32'd11, 32'd0, 32'd0, 1'b0, 8'h1F), 1'b0, '0},
      '{mk(32'd60, 32'd0, 32'd100, 32'd0, 32'd11, 32'd0, 1'b1, 8'h0F), 1'b0, '0},
      '{mk(32'd60, 32'd0, 32'd100, 32'd11, 32'd11, 32'd11, 1'b1, 8'hFE), 1'b0, '0}
    };

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < int'(N_DIRECTED); i++) begin
      want = dir_tab[i].typed ? dir_tab[i].want : predict_quality(dir_tab[i].snap, link_cfg);
      send_snapshot(dir_tab[i].snap, want, pick_gap());
    end

    // Random phases. Registers change only once the pipeline has emptied; the
    // calm phase runs with no gaps and no stalls at all.
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        program_settings(pick_settings(ph));
      end
      calm = (ph == 3);
      repeat (ITEMS_PER_PHASE) begin
        snap = gen_snapshot(link_cfg);
        send_snapshot(snap, predict_quality(snap, link_cfg), pick_gap());
        // Now and then the sender holds off until the pipeline is empty.
        if ($urandom_range(0, 149) == 0) begin
          settle();
        end
      end
    end

    settle();
    repeat (8) @(negedge clk);

    $display("Sent %0d snapshot items (%0d directed) under %0d register settings,",
             n_sent, N_DIRECTED, N_PHASES);
    $display("checked %0d results: %0d fresh, %0d poor, %0d stale, %0d unavailable.",
             n_checked, n_by_reason[REASON_NONE], n_by_reason[REASON_POOR],
             n_by_reason[REASON_STALE], n_by_reason[REASON_UNAVAIL]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
